[sv/mwac_pkg.sv]
// Shared types, constants and helpers for the address window access checker.
// Used by every module of the block but mwac_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mwac_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned PermW  = 3;
  localparam int unsigned WidthW = 4;

  localparam logic [PermW-1:0] PERM_READ  = 3'b001;
  localparam logic [PermW-1:0] PERM_WRITE = 3'b010;
  localparam logic [PermW-1:0] PERM_PROBE = 3'b100;

  localparam logic [WidthW-1:0] WIDTH_FIELD_MASK = 4'h f;
  localparam logic [WidthW-1:0] WIDTH_BIT_1B = 4'b0001;
  localparam logic [WidthW-1:0] WIDTH_BIT_2B = 4'b0010;
  localparam logic [WidthW-1:0] WIDTH_BIT_4B = 4'b0100;
  localparam logic [WidthW-1:0] WIDTH_BIT_8B = 4'b1000;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_CHECK    = 1'b1
  } op_e;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic {
    REG_ENABLED   = 1'b0,
    REG_WR_LOCKED = 1'b1
  } cfg_reg_e;

  // Classified request as it travels from the front end to the scan engine.
  // For a check, perms holds the needed permission and widths the width bit.
  typedef struct packed {
    op_e               op;
    logic              pre_ok;
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  end_addr;
    logic [PermW-1:0]  perms;
    logic [WidthW-1:0] widths;
    logic              probe;
  } item_t;

  // One window of the table. The end address is kept instead of the length;
  // a stored window never wraps, so both forms give the same answers.
  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  end_addr;
    logic [PermW-1:0]  perms;
    logic [WidthW-1:0] widths;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [WidthW-1:0] width_code(input logic [3:0] bytes);
    logic [WidthW-1:0] code;
    case (bytes)
      4'd1:    code = WIDTH_BIT_1B;
      4'd2:    code = WIDTH_BIT_2B;
      4'd4:    code = WIDTH_BIT_4B;
      4'd8:    code = WIDTH_BIT_8B;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[sv/mwac_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Holds the window table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mwac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/mwac_front.sv]
// Front end: configuration registers, request acceptance and classification.
// Depends on mwac_pkg; feeds the request queue.
`timescale 1ns / 1ps
`default_nettype none

module mwac_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation_i,
  input  wire logic [mwac_pkg::AddrW-1:0]    address_i,
  input  wire logic [mwac_pkg::AddrW-1:0]    window_size_i,
  input  wire logic [mwac_pkg::PermW-1:0]    permission_bits_i,
  input  wire logic [mwac_pkg::WidthW-1:0]   width_mask_i,
  input  wire logic [3:0]                    access_bytes_i,
  input  wire logic                          is_write_i,
  input  wire logic                          probe_only_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output mwac_pkg::item_t                    item_o
);
  import mwac_pkg::*;

  logic             enabled_q, enabled_d;
  logic             wr_locked_q, wr_locked_d;
  logic             cfg_wr;
  cfg_reg_e         cfg_sel;
  logic [AddrW-1:0] operand;
  logic [AddrW:0]   sum;
  logic [WidthW-1:0] bit_code;
  logic             align_ok;
  logic             reg_ok;
  logic             acc_ok;
  logic             is_check;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    enabled_d   = enabled_q;
    wr_locked_d = wr_locked_q;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_ENABLED:   enabled_d   = pwdata[0];
        REG_WR_LOCKED: wr_locked_d = pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ENABLED:   prdata = {31'd0, enabled_q};
      REG_WR_LOCKED: prdata = {31'd0, wr_locked_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      wr_locked_q <= 1'b0;
    end else begin
      enabled_q   <= enabled_d;
      wr_locked_q <= wr_locked_d;
    end
  end

  // One shared adder gives the window end for a registration and the
  // access end for a check; its carry flags a wrap past the top.
  assign is_check = (op_e'(operation_i) == OP_CHECK);
  assign operand  = is_check ? {{(AddrW-4){1'b0}}, access_bytes_i} : window_size_i;
  assign sum      = {1'b0, address_i} + {1'b0, operand};
  assign bit_code = width_code(access_bytes_i);
  assign align_ok = ((address_i[3:0] & (access_bytes_i - 4'd1)) == 4'd0);

  assign reg_ok = (window_size_i != '0) && !sum[AddrW] &&
                  ((permission_bits_i & (PERM_READ | PERM_WRITE)) != '0) &&
                  ((width_mask_i & WIDTH_FIELD_MASK) != '0);
  assign acc_ok = (bit_code != '0) && align_ok && !sum[AddrW] &&
                  !(is_write_i && wr_locked_q);

  always_comb begin
    item_o.op       = op_e'(operation_i);
    item_o.pre_ok   = enabled_q && (is_check ? acc_ok : reg_ok);
    item_o.addr     = address_i;
    item_o.end_addr = sum[AddrW-1:0];
    item_o.perms    = is_check ? (is_write_i ? PERM_WRITE : PERM_READ) : permission_bits_i;
    item_o.widths   = is_check ? bit_code : (width_mask_i & WIDTH_FIELD_MASK);
    item_o.probe    = probe_only_i;
  end

  assign busy   = q_full_i;
  assign push_o = start && !q_full_i;

endmodule

`default_nettype wire

[sv/mwac_queue.sv]
// Short request queue between the front end and the scan engine.
// Depends on mwac_pkg for the request type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mwac_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mwac_pkg::item_t item_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output mwac_pkg::item_t      head_o
);
  import mwac_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            slot_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[sv/mwac_back.sv]
// Scan engine: walks the window table one entry per cycle for overlap or
// containment, appends new windows and drives the result. Uses mwac_pkg, mwac_ram.
`timescale 1ns / 1ps
`default_nettype none

module mwac_back #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire mwac_pkg::item_t head_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic                 accepted_o,
  output logic [3:0]           window_index_o,
  output logic [4:0]           windows_in_use_o
);
  import mwac_pkg::*;

  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e          state_q, state_d;
  item_t           item_q, item_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] total_q, total_d;
  logic            done_q, done_d;
  logic            acc_q, acc_d;
  logic [3:0]      index_q, index_d;

  item_t           cur;
  entry_t          wentry;
  entry_t          rentry;
  logic [EntryW-1:0] rdata;
  logic            ram_we;
  logic [IdxW-1:0] raddr;
  logic            table_full;
  logic            last;
  logic            overlap;
  logic            contain;
  logic            hit;

  assign cur             = (state_q == ST_IDLE) ? head_i : item_q;
  assign wentry.base     = cur.addr;
  assign wentry.end_addr = cur.end_addr;
  assign wentry.perms    = cur.perms;
  assign wentry.widths   = cur.widths;
  assign rentry          = entry_t'(rdata);

  mwac_ram #(
    .Width (EntryW),
    .Depth (MAX_WINDOWS),
    .AddrW (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[IdxW-1:0]),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign table_full = (total_q == CntW'(MAX_WINDOWS));
  assign last       = ((CntW'(idx_q) + CntW'(1)) == total_q);

  // Read data always belongs to entry idx_q while scanning.
  assign overlap = (item_q.addr < rentry.end_addr) && (rentry.base < item_q.end_addr);
  assign contain = (item_q.addr >= rentry.base) && (item_q.end_addr <= rentry.end_addr) &&
                   ((rentry.perms & item_q.perms) != '0) &&
                   ((rentry.widths & item_q.widths) != '0) &&
                   (!item_q.probe || ((rentry.perms & PERM_PROBE) != '0));
  assign hit     = (item_q.op == OP_REGISTER) ? overlap : contain;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    idx_d   = idx_q;
    total_d = total_q;
    done_d  = 1'b0;
    acc_d   = 1'b0;
    index_d = '0;
    ram_we  = 1'b0;
    raddr   = '0;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o  = 1'b1;
          item_d = head_i;
          idx_d  = '0;
          if (!head_i.pre_ok || (head_i.op == OP_REGISTER && table_full)) begin
            done_d = 1'b1;
          end else if (total_q == '0) begin
            // Empty table: nothing to scan.
            done_d = 1'b1;
            if (head_i.op == OP_REGISTER) begin
              ram_we  = 1'b1;
              acc_d   = 1'b1;
              index_d = 4'(total_q);
              total_d = total_q + CntW'(1);
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        raddr = idx_q + IdxW'(1);
        if (hit) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (item_q.op == OP_CHECK) begin
            acc_d   = 1'b1;
            index_d = 4'(idx_q);
          end
        end else if (last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (item_q.op == OP_REGISTER) begin
            ram_we  = 1'b1;
            acc_d   = 1'b1;
            index_d = 4'(total_q);
            total_d = total_q + CntW'(1);
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
      index_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
      index_q <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign done_o           = done_q;
  assign accepted_o       = acc_q;
  assign window_index_o   = index_q;
  assign windows_in_use_o = 5'(total_q);

endmodule

`default_nettype wire

[sv/mmio_window_access_checker_unit.sv]
// Top level of the address window access checker.
// Depends on mwac_pkg, mwac_front, mwac_queue, mwac_back and mwac_ram.
//
// Usage: a request (register a window, or check an access) is taken at a
// rising edge where start is high and busy is low. Each request gives exactly
// one result, shown on accepted_o, window_index_o and windows_in_use_o for a
// single cycle while done_o is high; the receiver cannot stall it.
// Configuration (enabled at byte 0, writes_locked at byte 4) goes through the
// APB-style port; pready is always high and reads return the register value.
// Accepted requests wait in a two-entry queue; busy is high while it is full.
// The scan engine reads one table entry per cycle from the window RAM and
// handles one request at a time; the next request waits in the queue until
// the engine is back in idle. A request refused early or sent to an empty
// table needs no scan. A registration scans until the first overlapping
// window, which refuses it, or through all held windows; a check stops at
// the first matching window.
// Reset empties the table, sets enabled to 1 and writes_locked to 0; the
// table RAM needs no clearing since only slots below the window count are compared.
`timescale 1ns / 1ps
`default_nettype none

module mmio_window_access_checker_unit #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation_i,
  input  wire logic [mwac_pkg::AddrW-1:0]    address_i,
  input  wire logic [mwac_pkg::AddrW-1:0]    window_size_i,
  input  wire logic [mwac_pkg::PermW-1:0]    permission_bits_i,
  input  wire logic [mwac_pkg::WidthW-1:0]   width_mask_i,
  input  wire logic [3:0]                    access_bytes_i,
  input  wire logic                          is_write_i,
  input  wire logic                          probe_only_i,
  output logic                               done_o,
  output logic                               accepted_o,
  output logic [3:0]                         window_index_o,
  output logic [4:0]                         windows_in_use_o
);
  import mwac_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  mwac_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .window_size_i     (window_size_i),
    .permission_bits_i (permission_bits_i),
    .width_mask_i      (width_mask_i),
    .access_bytes_i    (access_bytes_i),
    .is_write_i        (is_write_i),
    .probe_only_i      (probe_only_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .item_o            (front_item)
  );

  mwac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_item)
  );

  mwac_back #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (q_valid),
    .head_i           (head_item),
    .pop_o            (pop),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .window_index_o   (window_index_o),
    .windows_in_use_o (windows_in_use_o)
  );

endmodule

`default_nettype wire

[bench/mmio_window_access_checker_unit_test.sv]
// Self-checking testbench for the address window access checker.
// Depends on mwac_pkg and mmio_window_access_checker_unit; drives requests
// and APB configuration writes and checks every result against its own model.
`timescale 1ns / 1ps

module mmio_window_access_checker_unit_test;
  import mwac_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] GRID_BASE = 64'h0000_7f00_0000_0000;
  localparam logic [63:0] FILL_BASE = 64'h0000_2000_0000_0000;
  localparam logic [63:0] TOP_BASE  = 64'hffff_ffff_ffff_e000;

  typedef struct packed {
    op_e         op;
    logic [63:0] addr;
    logic [63:0] size;
    logic [2:0]  perms;
    logic [3:0]  widths;
    logic [3:0]  nbytes;
    logic        wr;
    logic        probe;
  } request_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] slot;
    logic [4:0] count;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [63:0] address_i = '0;
  logic [63:0] window_size_i = '0;
  logic [2:0]  permission_bits_i = '0;
  logic [3:0]  width_mask_i = '0;
  logic [3:0]  access_bytes_i = '0;
  logic        is_write_i = 1'b0;
  logic        probe_only_i = 1'b0;
  logic        done_o;
  logic        accepted_o;
  logic [3:0]  window_index_o;
  logic [4:0]  windows_in_use_o;

  mmio_window_access_checker_unit #(
    .MAX_WINDOWS(TABLE_DEPTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .window_size_i    (window_size_i),
    .permission_bits_i(permission_bits_i),
    .width_mask_i     (width_mask_i),
    .access_bytes_i   (access_bytes_i),
    .is_write_i       (is_write_i),
    .probe_only_i     (probe_only_i),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .window_index_o   (window_index_o),
    .windows_in_use_o (windows_in_use_o)
  );

  // Model of the window table and configuration.
  logic [63:0] tbl_base [TABLE_DEPTH];
  logic [63:0] tbl_len [TABLE_DEPTH];
  logic [2:0]  tbl_perm [TABLE_DEPTH];
  logic [3:0]  tbl_widths [TABLE_DEPTH];
  logic [4:0]  tbl_count = '0;
  logic        cfg_enabled = 1'b1;
  logic        cfg_locked = 1'b0;

  request_t request_q[$];
  verdict_t verdict_q[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned granted_count = 0;
  int unsigned refused_count = 0;
  int unsigned reg_writes = 0;

  // Driver state.
  request_t    cur_req;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  logic        hold_off = 1'b0;
  logic        steady = 1'b0;
  logic        go = 1'b0;

  function automatic verdict_t judge_request(input request_t r);
    verdict_t    v;
    logic [63:0] last;
    logic [63:0] nb;
    logic [3:0]  wbit;
    logic [2:0]  need;
    logic        hit;
    v.ok = 1'b0;
    v.slot = '0;
    if (cfg_enabled && r.op == OP_REGISTER) begin
      if (r.size != 0 && r.addr <= ~r.size && tbl_count < TABLE_DEPTH &&
          (r.perms & (PERM_READ | PERM_WRITE)) != 0 && r.widths != 0) begin
        last = r.addr + r.size;
        hit = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
          if (r.addr < tbl_base[i] + tbl_len[i] && tbl_base[i] < last) hit = 1'b1;
        end
        if (!hit) begin
          tbl_base[tbl_count] = r.addr;
          tbl_len[tbl_count] = r.size;
          tbl_perm[tbl_count] = r.perms;
          tbl_widths[tbl_count] = r.widths;
          v.ok = 1'b1;
          v.slot = tbl_count[3:0];
          tbl_count = tbl_count + 1'b1;
        end
      end
    end else if (cfg_enabled) begin
      case (r.nbytes)
        4'd1:    wbit = WIDTH_BIT_1B;
        4'd2:    wbit = WIDTH_BIT_2B;
        4'd4:    wbit = WIDTH_BIT_4B;
        4'd8:    wbit = WIDTH_BIT_8B;
        default: wbit = '0;
      endcase
      nb = 64'(r.nbytes);
      need = r.wr ? PERM_WRITE : PERM_READ;
      if (wbit != 0 && (r.addr & (nb - 1)) == 0 && r.addr <= ~nb &&
          !(r.wr && cfg_locked)) begin
        last = r.addr + nb;
        for (int i = 0; i < tbl_count && !v.ok; i++) begin
          if (r.addr >= tbl_base[i] && last <= tbl_base[i] + tbl_len[i] &&
              (tbl_perm[i] & need) != 0 && (tbl_widths[i] & wbit) != 0 &&
              (!r.probe || (tbl_perm[i] & PERM_PROBE) != 0)) begin
            v.ok = 1'b1;
            v.slot = 4'(i);
          end
        end
      end
    end
    v.count = tbl_count;
    return v;
  endfunction

  function automatic request_t make_request(input op_e op, input logic [63:0] addr,
                                            input logic [63:0] size,
                                            input logic [2:0] perms,
                                            input logic [3:0] widths,
                                            input logic [3:0] nbytes,
                                            input logic wr, input logic probe);
    request_t r;
    r.op = op;
    r.addr = addr;
    r.size = size;
    r.perms = perms;
    r.widths = widths;
    r.nbytes = nbytes;
    r.wr = wr;
    r.probe = probe;
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.op = op_e'($urandom_range(0, 1));
    r.addr = {$urandom, $urandom};
    r.size = {$urandom, $urandom};
    r.perms = 3'($urandom_range(0, 7));
    r.widths = 4'($urandom_range(0, 15));
    r.nbytes = 4'($urandom_range(0, 15));
    r.wr = 1'($urandom_range(0, 1));
    r.probe = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic request_t window_request();
    request_t r;
    r = noise_request();
    r.op = OP_REGISTER;
    if ($urandom_range(0, 7) == 0) begin
      // Odd windows: anywhere in the address space, mostly refused.
      r.size = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 4096));
    end else begin
      // Grid of neighborhoods so that some windows collide and some fit.
      r.addr = GRID_BASE + 64'($urandom_range(0, 23)) * 64'h1000 +
               64'($urandom_range(0, 383)) * 8;
      r.size = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 2304)) :
               64'($urandom_range(1, 288)) * 8;
    end
    if (r.perms[1:0] == 2'b00 && $urandom_range(0, 4) != 0) r.perms[0] = 1'b1;
    if (r.widths == '0 && $urandom_range(0, 4) != 0) r.widths = WIDTH_FIELD_MASK;
    return r;
  endfunction

  function automatic request_t access_request();
    request_t    r;
    int unsigned pick;
    logic [63:0] span;
    logic [63:0] off;
    r = noise_request();
    r.op = OP_CHECK;
    case ($urandom_range(0, 3))
      0:       r.nbytes = 4'd1;
      1:       r.nbytes = 4'd2;
      2:       r.nbytes = 4'd4;
      default: r.nbytes = 4'd8;
    endcase
    if ($urandom_range(0, 9) == 0) r.nbytes = 4'($urandom_range(0, 15));
    r.probe = ($urandom_range(0, 3) == 0);
    if (tbl_count == 0) return r;
    pick = $urandom_range(0, int'(tbl_count) - 1);
    span = tbl_len[pick];
    case ($urandom_range(0, 5))
      0:       off = span - 64'(r.nbytes);
      1:       off = -64'(r.nbytes);
      2:       off = span;
      default: off = {$urandom, $urandom} % span;
    endcase
    r.addr = tbl_base[pick] + off;
    if (r.nbytes != 0 && $urandom_range(0, 7) != 0) r.addr &= ~(64'(r.nbytes) - 1);
    return r;
  endfunction

  function automatic request_t random_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return noise_request();
    if (roll < ((tbl_count < TABLE_DEPTH) ? 40 : 18)) return window_request();
    return access_request();
  endfunction

  task automatic submit(input request_t r);
    while (request_q.size() > 1) @(posedge clk_i);
    request_q.push_back(r);
  endtask

  task automatic feed_random(input int unsigned n);
    repeat (n) submit(random_request());
  endtask

  // Waits until every request has been taken and answered.
  task automatic drain();
    while (request_q.size() != 0 || go || start || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'($urandom_range(0, 32'h7fff_ffff)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ENABLED) cfg_enabled = value;
    else cfg_locked = value;
    reg_writes++;
  endtask

  task automatic check_reg(input cfg_reg_e idx, input logic want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("register %s readback: expected %0b, got %0b", idx.name(), want, prdata[0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests sent", cycle_count, sent_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Request driver: holds start until the block takes the request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        verdict_q.push_back(judge_request(cur_req));
        sent_count++;
      end
      if (!(start && busy)) begin
        if (hold_off && verdict_q.size() == 0) hold_off = 1'b0;
        go = 1'b0;
        if (hold_off) begin
          go = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() == 0) begin
          go = 1'b0;
        end else if (!steady && calm_left == 0 && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
        end else if (!steady && $urandom_range(0, 79) == 0) begin
          hold_off = 1'b1;
        end else begin
          go = 1'b1;
        end
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
        if (go) begin
          cur_req = request_q.pop_front();
          operation_i <= cur_req.op;
          address_i <= cur_req.addr;
          window_size_i <= cur_req.size;
          permission_bits_i <= cur_req.perms;
          width_mask_i <= cur_req.widths;
          access_bytes_i <= cur_req.nbytes;
          is_write_i <= cur_req.wr;
          probe_only_i <= cur_req.probe;
        end
        start <= go;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ok=%0b idx=%0d used=%0d",
                   accepted_o, window_index_o, windows_in_use_o);
      end else begin
        if (verdict_q[0].ok) granted_count++;
        else refused_count++;
        if (accepted_o !== verdict_q[0].ok || window_index_o !== verdict_q[0].slot ||
            windows_in_use_o !== verdict_q[0].count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected ok=%0b idx=%0d used=%0d, got ok=%0b idx=%0d used=%0d",
                     granted_count + refused_count, verdict_q[0].ok, verdict_q[0].slot,
                     verdict_q[0].count, accepted_o, window_index_o, windows_in_use_o);
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(REG_ENABLED, 1'b1);
    check_reg(REG_WR_LOCKED, 1'b0);
    write_reg(REG_WR_LOCKED, 1'b0);
    write_reg(REG_ENABLED, 1'b1);

    // Directed requests: refusal reasons first, then edge windows and accesses.
    submit(make_request(OP_CHECK, 64'h0, 64'h0, 3'h0, 4'h0, 4'd1, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'h1000, 64'h0, 3'h3, 4'hf, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'hffff_ffff_ffff_f000, 64'h1000, 3'h3, 4'hf,
                        4'd0, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'h1000, 64'h100, PERM_PROBE, 4'hf, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'h1000, 64'h100, 3'h3, 4'h0, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'h0, 64'h100, 3'h3, WIDTH_FIELD_MASK, 4'd0,
                        1'b0, 1'b0));
    submit(make_request(OP_REGISTER, TOP_BASE, 64'h1fff, 3'h7, WIDTH_FIELD_MASK, 4'd0,
                        1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'hf8, 64'h10, 3'h3, 4'hf, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_REGISTER, 64'h100, 64'h100, PERM_READ,
                        WIDTH_BIT_1B | WIDTH_BIT_4B, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h0, 64'h0, 3'h0, 4'h0, 4'd8, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h0, 64'h0, 3'h0, 4'h0, 4'd3, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h0, 64'h0, 3'h0, 4'h0, 4'd0, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h2, 64'h0, 3'h0, 4'h0, 4'd4, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'hffff_ffff_ffff_fff8, 64'h0, 3'h0, 4'h0, 4'd8,
                        1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'hffff_ffff_ffff_fff0, 64'h0, 3'h0, 4'h0, 4'd8,
                        1'b0, 1'b1));
    submit(make_request(OP_CHECK, 64'h100, 64'h0, 3'h0, 4'h0, 4'd1, 1'b1, 1'b0));
    submit(make_request(OP_CHECK, 64'h100, 64'h0, 3'h0, 4'h0, 4'd2, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h1fc, 64'h0, 3'h0, 4'h0, 4'd4, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'h10, 64'h0, 3'h0, 4'h0, 4'd1, 1'b0, 1'b1));
    submit(make_request(OP_CHECK, 64'hf8, 64'h0, 3'h0, 4'h0, 4'd8, 1'b1, 1'b0));
    submit(make_request(OP_CHECK, 64'h200, 64'h0, 3'h0, 4'h0, 4'd1, 1'b0, 1'b0));
    submit(make_request(OP_CHECK, 64'hffff_ffff_ffff_fffe, 64'h0, 3'h0, 4'h0, 4'd1,
                        1'b1, 1'b0));
    submit(make_request(OP_CHECK, 64'hffff_ffff_ffff_ffff, 64'h0, 3'h0, 4'h0, 4'd1,
                        1'b0, 1'b0));

    feed_random(200);
    drain();
    write_reg(REG_WR_LOCKED, 1'b1);
    check_reg(REG_WR_LOCKED, 1'b1);
    feed_random(100);
    drain();
    write_reg(REG_ENABLED, 1'b0);
    check_reg(REG_ENABLED, 1'b0);
    feed_random(60);
    drain();
    write_reg(REG_ENABLED, 1'b1);
    write_reg(REG_WR_LOCKED, 1'b0);

    // Fill the table with far-apart windows; the surplus hits the full table.
    for (int n = 0; n < 18; n++) begin
      submit(make_request(OP_REGISTER, FILL_BASE + 64'(n) * 64'h1_0000,
                          64'($urandom_range(32, 4096)) * 8,
                          3'($urandom_range(1, 7)) | PERM_READ,
                          4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
    feed_random(100);
    steady = 1'b1;
    feed_random(100);
    drain();
    repeat (20) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked (%0d accepted, %0d refused)",
             sent_count, granted_count + refused_count, granted_count, refused_count);
    $display("%0d windows held at the end, %0d register writes across enable/lock settings",
             tbl_count, reg_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
